### rtl/hsld_pkg.sv
// ----------------------------------------------------------------------------
// hsld_pkg: shared types and constants of the secret line detector
// Keyword patterns, value phase codes and the result record passed from the
// line scanner to the output stage.
// ----------------------------------------------------------------------------
package hsld_pkg;

    // Keyword window length in bytes, newest byte included
    localparam int WINDOW_BYTES     = 12;
    localparam int WINDOW_BITS      = 8 * WINDOW_BYTES;
    localparam int HISTORY_BITS     = 8 * (WINDOW_BYTES - 1);
    // Line counter width and the width of the reported line number
    localparam int LINE_COUNT_BITS  = 32;
    localparam int LINE_NO_BITS     = 32;
    // Output data width, rounded up to whole bytes
    localparam int RESULT_BITS      = 1 + LINE_NO_BITS;
    localparam int OUT_DATA_BITS    = ((RESULT_BITS + 7) / 8) * 8;

    localparam int KEY_COUNT = 8;

    // Keywords, right aligned: the last character sits in the lowest byte
    localparam logic [WINDOW_BITS-1:0] KEY_PATTERN [KEY_COUNT] = '{
        WINDOW_BITS'("password"),
        WINDOW_BITS'("passwd"),
        WINDOW_BITS'("secret"),
        WINDOW_BITS'("api_key"),
        WINDOW_BITS'("apikey"),
        WINDOW_BITS'({"access_", "token"}),
        WINDOW_BITS'({"auth_", "token"}),
        WINDOW_BITS'({"private_", "key"})
    };
    localparam int KEY_LEN [KEY_COUNT] = '{8, 6, 6, 7, 6, 12, 10, 11};

    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    // Progress through the value part of a line
    typedef enum logic [2:0] {
        PHASE_BEFORE_EQ = 3'd0,
        PHASE_AFTER_EQ  = 3'd1,
        PHASE_OPENED    = 3'd2,
        PHASE_CONTENT   = 3'd3,
        PHASE_CLOSED    = 3'd4,
        PHASE_EMPTY     = 3'd5
    } phase_t;

    // One finished line, as handed to the output stage
    typedef struct packed {
        logic                    valid;
        logic                    secret_found;
        logic [LINE_NO_BITS-1:0] line_no;
    } line_result_t;

    // Fold A-Z to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    // True when any keyword ends at the newest byte of the window
    function automatic logic keyword_match(input logic [WINDOW_BITS-1:0] window);
        logic                   hit;
        logic [WINDOW_BITS-1:0] mask;
        hit = 1'b0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            mask = ~({WINDOW_BITS{1'b1}} << (8 * KEY_LEN[k]));
            if (((window ^ KEY_PATTERN[k]) & mask) == '0)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/hsld_line_scan.sv
// ----------------------------------------------------------------------------
// hsld_line_scan: per-line state and judgment
// Holds the lowered byte history, keyword flag, value phase and line counter,
// and forms the result of a line in the cycle its end-of-line item arrives.
// ----------------------------------------------------------------------------
module hsld_line_scan
    import hsld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   text_byte,
    input  logic         end_of_line,
    input  logic         new_file,
    output line_result_t result
);

    logic [HISTORY_BITS-1:0]    history_reg, history_next;
    logic                       keyword_reg, keyword_next;
    phase_t                     phase_reg, phase_next;
    logic [LINE_COUNT_BITS-1:0] count_reg, count_next;

    logic [HISTORY_BITS-1:0]    history_base;
    logic                       keyword_base;
    phase_t                     phase_base;
    logic [LINE_COUNT_BITS-1:0] count_base;
    logic [WINDOW_BITS-1:0]     window;
    logic [63:0]                count_wide;

    // Clear the line and the counter first when a new file starts
    always_comb
    begin
        history_base = new_file ? '0 : history_reg;
        keyword_base = new_file ? 1'b0 : keyword_reg;
        phase_base   = new_file ? PHASE_BEFORE_EQ : phase_reg;
        count_base   = new_file ? '0 : count_reg;
        window       = {history_base, fold_case(text_byte)};
    end

    // Advance the line state for one item
    always_comb
    begin
        history_next = history_base;
        keyword_next = keyword_base;
        phase_next   = phase_base;
        count_next   = count_base;
        if (end_of_line)
        begin
            if (count_base != {LINE_COUNT_BITS{1'b1}})
            begin
                count_next = count_base + 1'b1;
            end
            history_next = '0;
            keyword_next = 1'b0;
            phase_next   = PHASE_BEFORE_EQ;
        end
        else
        begin
            history_next = window[HISTORY_BITS-1:0];
            keyword_next = keyword_base | keyword_match(window);
            case (phase_base)
                PHASE_BEFORE_EQ:
                begin
                    if (text_byte == CHAR_EQUALS)
                    begin
                        phase_next = PHASE_AFTER_EQ;
                    end
                end
                PHASE_AFTER_EQ:
                begin
                    if (text_byte == CHAR_QUOTE)
                    begin
                        phase_next = PHASE_OPENED;
                    end
                end
                PHASE_OPENED:
                begin
                    phase_next = (text_byte == CHAR_QUOTE) ? PHASE_EMPTY : PHASE_CONTENT;
                end
                PHASE_CONTENT:
                begin
                    if (text_byte == CHAR_QUOTE)
                    begin
                        phase_next = PHASE_CLOSED;
                    end
                end
                default:
                begin
                    phase_next = phase_base;
                end
            endcase
        end
    end

    // Form the result of a finished line
    always_comb
    begin
        count_wide          = 64'(count_next);
        result.valid        = accept & end_of_line;
        result.secret_found = keyword_base & (phase_base == PHASE_CLOSED);
        result.line_no      = (count_wide > 64'h0000_0000_FFFF_FFFF)
                              ? {LINE_NO_BITS{1'b1}}
                              : count_wide[LINE_NO_BITS-1:0];
    end

    // Hold state between accepted items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            keyword_reg <= 1'b0;
            phase_reg   <= PHASE_BEFORE_EQ;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            history_reg <= history_next;
            keyword_reg <= keyword_next;
            phase_reg   <= phase_next;
            count_reg   <= count_next;
        end
    end

endmodule

### rtl/hardcoded_secret_line_detector_top.sv
// ----------------------------------------------------------------------------
// hardcoded_secret_line_detector_top: credential line detector
// Scans a text stream one byte per item and flags lines that look like a
// hardcoded credential, reporting each line with its number in the file.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one item per byte. tdata carries the byte, tlast
//   marks an item that ends the line instead of carrying a byte, tuser marks
//   the start of a new file (counter and line state cleared first).
//   Output stream m_axis: one item per line end, carrying the flag and the
//   one-based, saturating line number. Other items give no output.
//   Output path: a line-end result is registered in the result register, or
//   in the skid register while m_axis stalls or the skid register is in use.
//   Throughput: one item per cycle while s_axis_tready is high.
//   Stall: a two-entry output buffer (result register plus skid register)
//   lets the input keep flowing while one result waits; s_axis_tready drops
//   only when both entries are full.
//   Reset: rst_n clears the line state, the line counter and both output
//   entries; s_axis_tready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module hardcoded_secret_line_detector_top
    import hsld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] text_byte
    input  logic                     s_axis_tlast,   // end_of_line
    input  logic                     s_axis_tuser,   // [0] new_file
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata    // [0] secret_found,
                                                     // [32:1] line no, rest zero
);

    line_result_t             result;
    logic                     accept;
    logic [RESULT_BITS-1:0]   push_data;

    logic                     out_valid_reg, out_valid_next;
    logic [RESULT_BITS-1:0]   out_data_reg, out_data_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic [RESULT_BITS-1:0]   skid_data_reg, skid_data_next;
    logic                     out_free;

    assign s_axis_tready = ~skid_valid_reg;
    assign accept        = s_axis_tvalid & s_axis_tready;

    hsld_line_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .text_byte   (s_axis_tdata),
        .end_of_line (s_axis_tlast),
        .new_file    (s_axis_tuser),
        .result      (result)
    );

    assign push_data = {result.line_no, result.secret_found};

    // Move results through the result register and the skid register
    always_comb
    begin
        out_free        = ~out_valid_reg | m_axis_tready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = result.valid;
                skid_data_next  = push_data;
            end
            else
            begin
                out_valid_next = result.valid;
                out_data_next  = push_data;
            end
        end
        else if (result.valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Hold the output entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_BITS'(out_data_reg);

endmodule

### tb/tb_hardcoded_secret_line_detector_top.sv
// ----------------------------------------------------------------------------
// tb_hardcoded_secret_line_detector_top: self-checking bench of the detector
// Feeds text lines through the input stream and predicts every line verdict
// and line number. Results are checked in order as they leave the block.
// Both stream sides idle and stall at random. The output side holds off once
// for a long stretch, and the input side pauses at set points until every
// pending line result has been checked.
// ----------------------------------------------------------------------------
module tb_hardcoded_secret_line_detector_top;
    import hsld_pkg::*;

    localparam int WIN         = WINDOW_BYTES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT    = 29;

    // One input item as queued for the driver
    typedef struct packed {
        logic [7:0] text;
        logic       end_of_line;
        logic       new_file;
        logic       drain_first;
    } text_item_t;

    // Expected verdict of one finished line
    typedef struct packed {
        logic                    found;
        logic [LINE_NO_BITS-1:0] number;
    } line_verdict_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata = 8'd0;
    logic                     s_axis_tlast = 1'b0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    text_item_t    pending_items [$];
    line_verdict_t expected_lines [$];
    text_item_t    current_item;

    // Line scanner state of the prediction
    logic [7:0]                 recent_bytes [WIN-1];
    logic                       keyword_flag;
    phase_t                     phase;
    logic [LINE_COUNT_BITS-1:0] line_counter;

    string KEYWORDS [KEY_COUNT] = '{"password", "passwd", "secret", "api_key",
                                    "apikey", {"access_", "token"},
                                    {"auth_", "token"}, {"private_", "key"}};
    string FILLER = "abxyzQRT019 _.:-";

    int  errors = 0;
    int  cycle_count = 0;
    int  items_accepted = 0;
    int  lines_checked = 0;
    int  lines_flagged = 0;
    int  file_starts = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    bit  file_start_pending = 0;
    bit  drain_pending = 0;

    hardcoded_secret_line_detector_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] text_byte
        .s_axis_tlast  (s_axis_tlast),   // end_of_line
        .s_axis_tuser  (s_axis_tuser),   // [0] new_file
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [0] secret_found, [32:1] line no
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Clear the window, the keyword flag and the value phase
    task automatic clear_line_state();
        for (int i = 0; i < WIN - 1; i++)
        begin
            recent_bytes[i] = 8'd0;
        end
        keyword_flag = 1'b0;
        phase = PHASE_BEFORE_EQ;
    endtask

    // Shift one byte into the window, look for keywords, advance the phase
    task automatic scan_text_byte(input logic [7:0] b);
        logic [7:0] win [WIN];
        int         len;
        bit         hit;
        for (int i = 0; i < WIN - 1; i++)
        begin
            win[i] = recent_bytes[i];
        end
        win[WIN-1] = (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            len = KEYWORDS[k].len();
            hit = 1;
            for (int i = 0; i < len; i++)
            begin
                if (win[WIN-len+i] != KEYWORDS[k][i])
                begin
                    hit = 0;
                end
            end
            if (hit)
            begin
                keyword_flag = 1'b1;
            end
        end
        for (int i = 0; i < WIN - 1; i++)
        begin
            recent_bytes[i] = win[i+1];
        end
        case (phase)
            PHASE_BEFORE_EQ: if (b == CHAR_EQUALS) phase = PHASE_AFTER_EQ;
            PHASE_AFTER_EQ:  if (b == CHAR_QUOTE) phase = PHASE_OPENED;
            PHASE_OPENED:    phase = (b == CHAR_QUOTE) ? PHASE_EMPTY : PHASE_CONTENT;
            PHASE_CONTENT:   if (b == CHAR_QUOTE) phase = PHASE_CLOSED;
            default: ;
        endcase
    endtask

    // Work out what one accepted item causes
    task automatic predict_line(input text_item_t it, output bit produced,
                                output line_verdict_t v);
        longint unsigned wide;
        produced = 0;
        v = '0;
        if (it.new_file)
        begin
            clear_line_state();
            line_counter = '0;
        end
        if (!it.end_of_line)
        begin
            scan_text_byte(it.text);
        end
        else
        begin
            if (line_counter != '1)
            begin
                line_counter = line_counter + 1'b1;
            end
            wide = line_counter;
            v.found = keyword_flag && (phase == PHASE_CLOSED);
            v.number = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
            clear_line_state();
            produced = 1;
        end
    endtask

    // Queue helpers: a pending file start or drain mark goes on the next item
    task automatic push_item(input logic [7:0] b, input logic eol);
        text_item_t it;
        it.text = b;
        it.end_of_line = eol;
        it.new_file = file_start_pending;
        it.drain_first = drain_pending;
        file_start_pending = 0;
        drain_pending = 0;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            push_item(s[i], 1'b0);
        end
    endtask

    function automatic logic [7:0] filler_char();
        return FILLER[$urandom_range(0, FILLER.len() - 1)];
    endfunction

    // Push a keyword in random case, or a near miss of it
    task automatic push_keyword(input string key, input bit mangle);
        logic [7:0] c;
        int         bad;
        int         len;
        len = key.len();
        bad = $urandom_range(0, len - 1);
        if (mangle && $urandom_range(0, 1))
        begin
            len = len - 1;
            bad = -1;
        end
        for (int i = 0; i < len; i++)
        begin
            c = key[i];
            if (mangle && i == bad)
            begin
                c = filler_char();
            end
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
            begin
                c = c - 8'd32;
            end
            push_item(c, 1'b0);
        end
    endtask

    // Build one random line, mostly of the key = "value" shape
    task automatic add_random_line();
        int r;
        if ($urandom_range(0, 11) == 0)
        begin
            file_start_pending = 1;
        end
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            repeat ($urandom_range(0, 14)) push_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(0, 2)) push_item(filler_char(), 1'b0);
            if ($urandom_range(0, 29) == 0)
            begin
                file_start_pending = 1;
            end
            push_keyword(KEYWORDS[$urandom_range(0, KEY_COUNT - 1)],
                         $urandom_range(0, 99) >= 75);
            repeat ($urandom_range(0, 2)) push_item(filler_char(), 1'b0);
            if ($urandom_range(0, 99) < 85)
            begin
                repeat ($urandom_range(0, 1)) push_item(" ", 1'b0);
                push_item(CHAR_EQUALS, 1'b0);
                repeat ($urandom_range(0, 1)) push_item(" ", 1'b0);
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    push_item(CHAR_QUOTE, 1'b0);
                    repeat ($urandom_range(1, 4))
                    begin
                        push_item(($urandom_range(0, 7) == 0) ? CHAR_EQUALS
                                                              : filler_char(), 1'b0);
                    end
                    push_item(CHAR_QUOTE, 1'b0);
                end
                else if (r < 75)
                begin
                    push_item(CHAR_QUOTE, 1'b0);
                    push_item(CHAR_QUOTE, 1'b0);
                end
                else if (r < 85)
                begin
                    push_item(CHAR_QUOTE, 1'b0);
                    repeat ($urandom_range(1, 3)) push_item(filler_char(), 1'b0);
                end
                else
                begin
                    repeat ($urandom_range(1, 3)) push_item(filler_char(), 1'b0);
                end
            end
            repeat ($urandom_range(0, 2)) push_item(filler_char(), 1'b0);
            // Add a late quote, equals sign or keyword now and then
            r = $urandom_range(0, 15);
            if (r == 0)
            begin
                push_item(CHAR_QUOTE, 1'b0);
            end
            else if (r == 1)
            begin
                push_item(CHAR_EQUALS, 1'b0);
            end
            else if (r == 2)
            begin
                push_keyword(KEYWORDS[$urandom_range(0, KEY_COUNT - 1)], 0);
            end
        end
        push_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Driver: advance on a handshake, idle at random, hold for a drain mark
    always @(posedge clk)
    begin : drive_input
        bit            produced;
        bit            quiet;
        line_verdict_t v;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_line(current_item, produced, v);
                items_accepted <= items_accepted + 1;
                if (current_item.new_file)
                begin
                    file_starts <= file_starts + 1;
                end
                if (produced)
                begin
                    expected_lines.insert(expected_lines.size(), v);
                end
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                quiet = (cycle_count >= 3000 && cycle_count < 4500);
                if (pending_items.size() != 0
                    && !(pending_items[0].drain_first && expected_lines.size() != 0)
                    && (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    current_item = pending_items.pop_front();
                    s_axis_tdata  <= current_item.text;
                    s_axis_tlast  <= current_item.end_of_line;
                    s_axis_tuser  <= current_item.new_file;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each line result, stall the output at random
    always @(posedge clk)
    begin : watch_output
        line_verdict_t e;
        bit            quiet;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: line result with none pending, actual tdata %h",
                             $time, m_axis_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    e = expected_lines.pop_front();
                    if (m_axis_tdata[0] !== e.found)
                    begin
                        $display("%0t: secret_found expected %0d actual %0d (line %0d)",
                                 $time, e.found, m_axis_tdata[0], e.number);
                        errors = errors + 1;
                    end
                    if (m_axis_tdata[LINE_NO_BITS:1] !== e.number)
                    begin
                        $display("%0t: line no expected %0d actual %0d",
                                 $time, e.number, m_axis_tdata[LINE_NO_BITS:1]);
                        errors = errors + 1;
                    end
                    if ((m_axis_tdata >> RESULT_BITS) !== '0)
                    begin
                        $display("%0t: tdata padding expected 0 actual %h",
                                 $time, m_axis_tdata >> RESULT_BITS);
                        errors = errors + 1;
                    end
                    if (e.found)
                    begin
                        lines_flagged = lines_flagged + 1;
                    end
                end
                lines_checked = lines_checked + 1;
            end
            // Hold off once for a long stretch so the block backs up
            quiet = (cycle_count >= 3000 && cycle_count < 4500);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && lines_checked >= 20)
            begin
                hold_done = 1;
                hold_left = 300;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Give up when the run takes far longer than it should
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("tb_hardcoded_secret_line_detector_top NOT OK");
        $finish;
    end

    initial
    begin
        int random_start;
        clear_line_state();
        line_counter = '0;

        // Directed lines: bare line end first, a match, file start on a line
        // end, and a mixed-case keyword with an empty literal
        push_item(8'hFF, 1'b1);
        push_text("apikey=\"k\"");
        push_item(8'h00, 1'b1);
        file_start_pending = 1;
        push_item(8'h5A, 1'b1);
        push_text("SEcReT=\"\"");
        push_item(8'h22, 1'b1);

        // Random lines, with drain points at the start and near the middle
        random_start = pending_items.size();
        drain_pending = 1;
        while (pending_items.size() - random_start < RANDOM_ITEMS)
        begin
            if (pending_items.size() - random_start >= RANDOM_ITEMS / 2
                && pending_items.size() - random_start < RANDOM_ITEMS / 2 + 20)
            begin
                drain_pending = 1;
            end
            add_random_line();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all items, then for all line results
        @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid)
        begin
            @(negedge clk);
        end
        while (expected_lines.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        $display("ran %0d items over %0d file starts; checked %0d line results, %0d flagged",
                 items_accepted, file_starts, lines_checked, lines_flagged);
        if (errors == 0 && expected_lines.size() == 0)
        begin
            $display("tb_hardcoded_secret_line_detector_top OK");
        end
        else
        begin
            $display("tb_hardcoded_secret_line_detector_top NOT OK");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/hsld_pkg.sv
rtl/hsld_line_scan.sv
rtl/hardcoded_secret_line_detector_top.sv
tb/tb_hardcoded_secret_line_detector_top.sv
